/* rtl/swhsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhsr_pkg
// Shared types, constants and helper functions of the single-wire humidity
// sensor reader.
// ----------------------------------------------------------------------------
package swhsr_pkg;

	localparam int CNT_W_DEF     = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int IN_TDATA_W    = 8;
	localparam int OUT_TDATA_W   = 40;
	localparam int BITS_PER_BYTE = 8;
	localparam int FRAME_BYTES   = 5;
	localparam int DIGIT_BASE    = 10;

	localparam logic [CFG_IDX_W-1:0] REG_START_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_DELAY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd3;

	localparam logic [15:0] START_LOW_RST    = 16'd19000;
	localparam logic [7:0]  RESP_DELAY_RST   = 8'd40;
	localparam logic [7:0]  SAMPLE_DELAY_RST = 8'd30;
	localparam logic [15:0] TIMEOUT_RST      = 16'd254;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_START_LOW = 3'd1,
		PH_RELEASE   = 3'd2,
		PH_RESP_LOW  = 3'd3,
		PH_RESP_HIGH = 3'd4,
		PH_BIT_RISE  = 3'd5,
		PH_BIT_DELAY = 3'd6,
		PH_BIT_FALL  = 3'd7
	} phase_t;

	typedef struct packed {
		logic [15:0] start_low;
		logic [7:0]  resp_delay;
		logic [7:0]  sample_delay;
		logic [15:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy;
		logic       done;
		logic       response_seen;
		logic       checksum_ok;
		logic [7:0] temp_int;
		logic [7:0] hum_int;
	} status_t;

	// Quotient by ten through a reciprocal multiply; exact for all byte values.
	function automatic logic [4:0] tens_of(input logic [7:0] v);
		logic [15:0] prod;
		begin
			prod = 16'(v) * 16'd205;
			tens_of = prod[15:11];
		end
	endfunction

	function automatic logic [3:0] ones_of(input logic [7:0] v);
		logic [7:0] back;
		logic [7:0] rem;
		begin
			back = 8'(tens_of(v) * 8'(DIGIT_BASE));
			rem = v - back;
			ones_of = rem[3:0];
		end
	endfunction

endpackage

/* rtl/single_wire_humidity_sensor_reader.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader
// Reads a one-wire temperature and humidity sensor, one input beat per tick.
//
// Channel    Direction  Beat contents
// s_axis     in         one tick: start request and sampled wire level
// m_axis     out        one status beat per input beat
// cfg        in         register writes, taken at once
//
// Each input beat yields its output beat in the cycle after acceptance.
// A new beat is taken every cycle; the sequencer state and the output
// register are the only storage on the path. The input side stalls only
// while an output beat is held and not taken. Reset clears the sequencer,
// the latched bytes and the registers to their defaults.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader #(
	parameter int CNT_W = swhsr_pkg::CNT_W_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// start_read, pin_level, zero fill
	input  logic [swhsr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// drive_low, busy_res, done_res, response_seen, checksum_ok, temp_tens,
	// temp_ones, hum_tens, hum_ones, temp_int, hum_int, zero fill
	output logic [swhsr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [swhsr_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [swhsr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import swhsr_pkg::*;

	cfg_t                   cfg_q;
	status_t                stat_d;
	logic                   accept;
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic [OUT_TDATA_W-1:0] pack;
	logic [4:0]             t_tens, h_tens;
	logic [3:0]             t_ones, h_ones;

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low <= START_LOW_RST;
			cfg_q.resp_delay <= RESP_DELAY_RST;
			cfg_q.sample_delay <= SAMPLE_DELAY_RST;
			cfg_q.timeout <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_START_LOW:    cfg_q.start_low <= cfg_wdata;
				REG_RESP_DELAY:   cfg_q.resp_delay <= cfg_wdata[7:0];
				REG_SAMPLE_DELAY: cfg_q.sample_delay <= cfg_wdata[7:0];
				REG_TIMEOUT:      cfg_q.timeout <= cfg_wdata;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	swhsr_core #(
		.CNT_W(CNT_W)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.en(accept),
		.start_read(s_axis_tdata[0]),
		.pin_level(s_axis_tdata[1]),
		.cfg(cfg_q),
		.stat_d(stat_d)
	);

	always_comb begin
		if (stat_d.response_seen) begin
			t_tens = tens_of(stat_d.temp_int);
			t_ones = ones_of(stat_d.temp_int);
			h_tens = tens_of(stat_d.hum_int);
			h_ones = ones_of(stat_d.hum_int);
		end else begin
			t_tens = '0;
			t_ones = '0;
			h_tens = '0;
			h_ones = '0;
		end
		pack = {1'b0, stat_d.hum_int, stat_d.temp_int, h_ones, h_tens, t_ones, t_tens,
			stat_d.checksum_ok, stat_d.response_seen, stat_d.done, stat_d.busy,
			stat_d.drive_low};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= pack;
		end
	end

endmodule

/* rtl/swhsr_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhsr_core
// Sensor sequencer: start pulse, response check, bit timing and frame
// checksum. Advances one tick per enabled cycle and presents the next status.
// ----------------------------------------------------------------------------
module swhsr_core #(
	parameter int CNT_W = swhsr_pkg::CNT_W_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              start_read,
	input  logic              pin_level,
	input  swhsr_pkg::cfg_t   cfg,
	output swhsr_pkg::status_t stat_d
);
	import swhsr_pkg::*;

	localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] tick_q, tick_d, tick_inc;
	logic [2:0]       bit_q, bit_d;
	logic [2:0]       byte_q, byte_d;
	logic [7:0]       shift_q, shift_d;
	logic [7:0]       frame_q [4];
	logic [7:0]       frame_d [4];
	logic [7:0]       latch_q [4];
	logic [7:0]       latch_d [4];
	logic             sample_q, sample_d;
	logic [1:0]       flags_q, flags_d;
	logic [15:0]      lim;
	logic             reached;
	logic             do_byte;
	logic [7:0]       byte_val;
	logic [9:0]       sum_w;
	logic             done;

	always_comb begin
		unique case (phase_q)
			PH_START_LOW: lim = cfg.start_low;
			PH_RELEASE:   lim = 16'(cfg.resp_delay);
			PH_BIT_DELAY: lim = 16'(cfg.sample_delay);
			default:      lim = cfg.timeout;
		endcase
		tick_inc = (tick_q == CNT_MAX) ? tick_q : tick_q + 1'b1;
		reached = (CMP_W'(tick_inc) >= CMP_W'(lim)) || (tick_inc == CNT_MAX);
		sum_w = 10'(frame_q[0]) + 10'(frame_q[1]) + 10'(frame_q[2]) + 10'(frame_q[3]);
	end

	always_comb begin
		phase_d = phase_q;
		tick_d = tick_q;
		bit_d = bit_q;
		byte_d = byte_q;
		shift_d = shift_q;
		frame_d = frame_q;
		latch_d = latch_q;
		sample_d = sample_q;
		flags_d = flags_q;
		done = 1'b0;
		do_byte = 1'b0;
		byte_val = shift_q;

		unique case (phase_q)
			PH_IDLE: begin
				if (start_read) begin
					phase_d = PH_START_LOW;
					tick_d = '0;
				end
			end
			PH_START_LOW: begin
				tick_d = tick_inc;
				if (reached) begin
					phase_d = PH_RELEASE;
					tick_d = '0;
				end
			end
			PH_RELEASE: begin
				tick_d = tick_inc;
				if (reached) begin
					tick_d = '0;
					if (!pin_level) begin
						phase_d = PH_RESP_LOW;
					end else begin
						flags_d = 2'b00;
						phase_d = PH_IDLE;
						done = 1'b1;
					end
				end
			end
			PH_RESP_LOW: begin
				if (pin_level) begin
					phase_d = PH_RESP_HIGH;
					tick_d = '0;
				end else begin
					tick_d = tick_inc;
					if (reached) begin
						phase_d = PH_RESP_HIGH;
						tick_d = '0;
					end
				end
			end
			PH_RESP_HIGH: begin
				if (!pin_level || reached) begin
					phase_d = PH_BIT_RISE;
					tick_d = '0;
					bit_d = '0;
					byte_d = '0;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_BIT_RISE: begin
				if (pin_level || reached) begin
					phase_d = PH_BIT_DELAY;
					tick_d = '0;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_BIT_DELAY: begin
				tick_d = tick_inc;
				if (reached) begin
					sample_d = pin_level;
					phase_d = PH_BIT_FALL;
					tick_d = '0;
				end
			end
			PH_BIT_FALL: begin
				if (!pin_level) begin
					byte_val = {shift_q[6:0], sample_q};
					shift_d = byte_val;
					if (bit_q == 3'(BITS_PER_BYTE - 1)) begin
						do_byte = 1'b1;
					end else begin
						bit_d = bit_q + 1'b1;
						phase_d = PH_BIT_RISE;
						tick_d = '0;
					end
				end else begin
					tick_d = tick_inc;
					if (reached) begin
						do_byte = 1'b1;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				tick_d = '0;
			end
		endcase

		if (do_byte) begin
			if (byte_q < 3'(FRAME_BYTES - 1)) begin
				frame_d[byte_q[1:0]] = byte_val;
			end
			bit_d = '0;
			tick_d = '0;
			if (byte_q >= 3'(FRAME_BYTES - 1)) begin
				byte_d = '0;
				if (sum_w[7:0] == byte_val) begin
					latch_d = frame_q;
					flags_d = 2'b11;
				end else begin
					flags_d = 2'b01;
				end
				phase_d = PH_IDLE;
				done = 1'b1;
			end else begin
				byte_d = byte_q + 1'b1;
				phase_d = PH_BIT_RISE;
			end
		end
	end

	always_comb begin
		stat_d.drive_low = (phase_d == PH_START_LOW);
		stat_d.busy = (phase_d != PH_IDLE);
		stat_d.done = done;
		stat_d.response_seen = flags_d[0];
		stat_d.checksum_ok = flags_d[1];
		stat_d.temp_int = latch_d[2];
		stat_d.hum_int = latch_d[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
			bit_q <= '0;
			byte_q <= '0;
			shift_q <= '0;
			frame_q <= '{default: '0};
			latch_q <= '{default: '0};
			sample_q <= 1'b0;
			flags_q <= 2'b00;
		end else if (en) begin
			phase_q <= phase_d;
			tick_q <= tick_d;
			bit_q <= bit_d;
			byte_q <= byte_d;
			shift_q <= shift_d;
			frame_q <= frame_d;
			latch_q <= latch_d;
			sample_q <= sample_d;
			flags_q <= flags_d;
		end
	end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the single-wire humidity sensor reader. A short
// table of ticks at the reset settings comes first. A sensor emulator then
// answers start pulses with frames of random bytes under several register
// settings. It also injects wire noise, missing answers, bad checksums and
// waits that run into the timeout. Every status beat is compared field by
// field with its table row or a cycle-level model of the sequencer. Input
// gaps come in random bursts and output stalls follow their own pattern.
// ----------------------------------------------------------------------------
module testbench;
	import swhsr_pkg::*;

	typedef struct packed {
		logic [7:0] hum_int;
		logic [7:0] temp_int;
		logic [3:0] hum_ones;
		logic [4:0] hum_tens;
		logic [3:0] temp_ones;
		logic [4:0] temp_tens;
		logic       checksum_ok;
		logic       response_seen;
		logic       done;
		logic       busy;
		logic       drive_low;
	} reading_t;

	typedef struct packed {
		logic     st;
		logic     pn;
		logic     typed;
		reading_t want;
	} step_row_t;

	localparam int unsigned CNT_TOP = (1 << CNT_W_DEF) - 1;
	localparam reading_t AT_REST = '0;
	localparam reading_t PULLING = '{drive_low: 1'b1, busy: 1'b1, default: '0};
	localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] = '{
		REG_START_LOW, REG_RESP_DELAY, REG_SAMPLE_DELAY, REG_TIMEOUT
	};

	localparam step_row_t DIRECTED [12] = '{
		'{1'b0, 1'b0, 1'b1, AT_REST},
		'{1'b0, 1'b1, 1'b1, AT_REST},
		'{1'b0, 1'b0, 1'b1, AT_REST},
		'{1'b0, 1'b1, 1'b1, AT_REST},
		'{1'b1, 1'b1, 1'b1, PULLING},
		'{1'b1, 1'b0, 1'b1, PULLING},
		'{1'b1, 1'b1, 1'b1, PULLING},
		'{1'b0, 1'b0, 1'b1, PULLING},
		'{1'b0, 1'b1, 1'b0, AT_REST},
		'{1'b1, 1'b0, 1'b0, AT_REST},
		'{1'b0, 1'b1, 1'b0, AT_REST},
		'{1'b1, 1'b1, 1'b0, AT_REST}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_addr = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	single_wire_humidity_sensor_reader u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sequencer model state and its copy of the registers.
	phase_t      ph = PH_IDLE;
	int unsigned tcnt = 0;
	int unsigned bit_i = 0;
	int unsigned byte_i = 0;
	logic [7:0]  shreg = '0;
	logic [7:0]  frm [4] = '{default: '0};
	logic [7:0]  lat [4] = '{default: '0};
	logic        smp = 1'b0;
	logic [1:0]  flg = '0;
	logic [15:0] c_sl = START_LOW_RST;
	logic [7:0]  c_rd = RESP_DELAY_RST;
	logic [7:0]  c_sd = SAMPLE_DELAY_RST;
	logic [15:0] c_to = TIMEOUT_RST;

	reading_t    status_due [$];
	int unsigned mismatches = 0;
	int unsigned beats_seen = 0;
	int unsigned ticks_sent = 0;
	int unsigned n_meas = 0;
	int unsigned n_latched = 0;
	int unsigned n_bad_sum = 0;
	int unsigned n_silent = 0;
	int unsigned n_settings = 1;

	// Sensor emulator and sender state.
	logic [7:0]  frame_plan [5];
	logic        respond = 1'b1;
	logic        noisy = 1'b0;
	phase_t      last_ph = PH_IDLE;
	int unsigned hold_left = 0;
	int unsigned fault_rate = 0;
	logic        force_fault = 1'b0;
	int unsigned burst_left = 0;
	logic        smooth = 1'b0;
	logic [10:0] rx_cnt;

	function automatic logic count_reached(input int unsigned lim);
		if (tcnt < CNT_TOP)
			tcnt++;
		return tcnt >= lim || tcnt == CNT_TOP;
	endfunction

	function automatic logic close_byte();
		logic [7:0] sum;
		if (byte_i < 4)
			frm[byte_i] = shreg;
		byte_i++;
		bit_i = 0;
		tcnt = 0;
		if (byte_i >= FRAME_BYTES) begin
			byte_i = 0;
			sum = frm[0] + frm[1] + frm[2] + frm[3];
			if (sum == shreg) begin
				lat = frm;
				flg = 2'b11;
			end else begin
				flg = 2'b01;
			end
			ph = PH_IDLE;
			return 1'b1;
		end
		ph = PH_BIT_RISE;
		return 1'b0;
	endfunction

	function automatic reading_t next_status(input logic st, input logic pn);
		reading_t   r;
		logic       fin;
		logic       hit;
		logic [7:0] t;
		logic [7:0] h;
		fin = 1'b0;
		case (ph)
			PH_IDLE: begin
				if (st) begin
					ph = PH_START_LOW;
					tcnt = 0;
				end
			end
			PH_START_LOW: begin
				if (count_reached(c_sl)) begin
					ph = PH_RELEASE;
					tcnt = 0;
				end
			end
			PH_RELEASE: begin
				if (count_reached(c_rd)) begin
					tcnt = 0;
					if (!pn) begin
						ph = PH_RESP_LOW;
					end else begin
						flg = 2'b00;
						ph = PH_IDLE;
						fin = 1'b1;
					end
				end
			end
			PH_RESP_LOW: begin
				hit = pn ? 1'b1 : count_reached(c_to);
				if (hit) begin
					ph = PH_RESP_HIGH;
					tcnt = 0;
				end
			end
			PH_RESP_HIGH: begin
				hit = !pn ? 1'b1 : count_reached(c_to);
				if (hit) begin
					ph = PH_BIT_RISE;
					tcnt = 0;
					bit_i = 0;
					byte_i = 0;
				end
			end
			PH_BIT_RISE: begin
				hit = pn ? 1'b1 : count_reached(c_to);
				if (hit) begin
					ph = PH_BIT_DELAY;
					tcnt = 0;
				end
			end
			PH_BIT_DELAY: begin
				if (count_reached(c_sd)) begin
					smp = pn;
					ph = PH_BIT_FALL;
					tcnt = 0;
				end
			end
			PH_BIT_FALL: begin
				if (!pn) begin
					shreg = {shreg[6:0], smp};
					bit_i++;
					if (bit_i >= BITS_PER_BYTE) begin
						fin = close_byte();
					end else begin
						ph = PH_BIT_RISE;
						tcnt = 0;
					end
				end else if (count_reached(c_to)) begin
					fin = close_byte();
				end
			end
			default: begin
				ph = PH_IDLE;
				tcnt = 0;
			end
		endcase
		if (fin) begin
			tcnt = 0;
			n_meas++;
			if (flg == 2'b11)
				n_latched++;
			else if (flg == 2'b01)
				n_bad_sum++;
			else
				n_silent++;
		end
		t = lat[2];
		h = lat[0];
		r = '0;
		r.drive_low = (ph == PH_START_LOW);
		r.busy = (ph != PH_IDLE);
		r.done = fin;
		r.response_seen = flg[0];
		r.checksum_ok = flg[1];
		if (flg[0]) begin
			r.temp_tens = 5'(t / DIGIT_BASE);
			r.temp_ones = 4'(t % DIGIT_BASE);
			r.hum_tens = 5'(h / DIGIT_BASE);
			r.hum_ones = 4'(h % DIGIT_BASE);
		end
		r.temp_int = t;
		r.hum_int = h;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (mismatches < 40)
			$display("beat %0d: %s is %0h, expected %0h", beats_seen, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch(name, got, want);
	endtask

	task automatic check_beat(input logic [OUT_TDATA_W-1:0] raw);
		reading_t got;
		reading_t want;
		got = raw[$bits(reading_t)-1:0];
		if (status_due.size() == 0) begin
			report_mismatch("beat with nothing pending", raw, 0);
			return;
		end
		want = status_due.pop_front();
		check_field("drive_low", got.drive_low, want.drive_low);
		check_field("busy_res", got.busy, want.busy);
		check_field("done_res", got.done, want.done);
		check_field("response_seen", got.response_seen, want.response_seen);
		check_field("checksum_ok", got.checksum_ok, want.checksum_ok);
		check_field("temp_tens", got.temp_tens, want.temp_tens);
		check_field("temp_ones", got.temp_ones, want.temp_ones);
		check_field("hum_tens", got.hum_tens, want.hum_tens);
		check_field("hum_ones", got.hum_ones, want.hum_ones);
		check_field("temp_int", got.temp_int, want.temp_int);
		check_field("hum_int", got.hum_int, want.hum_int);
		beats_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_cnt <= '0;
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_beat(m_axis_tdata);
			rx_cnt <= rx_cnt + 1'b1;
			m_axis_tready <= !(rx_cnt[7] && (rx_cnt[2:0] < rx_cnt[10:8]));
		end
	end

	// Presents one tick and returns at the edge where it is taken.
	task automatic send_tick(input logic st, input logic pn, input logic typed,
			input reading_t want);
		reading_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (!smooth && $urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W-2){1'b0}}, pn, st};
		do @(posedge clk); while (!s_axis_tready);
		r = next_status(st, pn);
		status_due.push_back(typed ? want : r);
		ticks_sent++;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_regs(input logic [15:0] sl, input logic [15:0] rd,
			input logic [15:0] sd, input logic [15:0] to);
		logic [15:0] vals [4];
		vals = '{sl, rd, sd, to};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= REG_ORDER[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		c_sl = sl;
		c_rd = rd[7:0];
		c_sd = sd[7:0];
		c_to = to;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic wait_fault();
		if (force_fault) begin
			force_fault = 1'b0;
			return 1'b1;
		end
		return $urandom_range(0, 999) < fault_rate;
	endfunction

	// Holds the wire at a level for a while after a phase is entered, then flips it.
	function automatic logic hold_pin(input logic entered, input logic level,
			input int unsigned longest);
		if (entered)
			hold_left = wait_fault() ? int'(c_to) + 1 : $urandom_range(0, longest);
		if (hold_left != 0) begin
			hold_left--;
			return level;
		end
		return !level;
	endfunction

	task automatic plan_frame(input logic answer);
		logic [7:0] sum;
		respond = answer;
		noisy = ($urandom_range(0, 7) == 0);
		for (int i = 0; i < 4; i++)
			frame_plan[i] = pick_byte();
		sum = frame_plan[0] + frame_plan[1] + frame_plan[2] + frame_plan[3];
		frame_plan[4] = ($urandom_range(0, 5) == 0) ? sum ^ (8'd1 << $urandom_range(0, 7))
			: sum;
		last_ph = PH_IDLE;
		hold_left = 0;
	endtask

	task automatic sensor_tick();
		logic entered;
		logic pn;
		logic bit_val;
		entered = (ph != last_ph);
		last_ph = ph;
		bit_val = frame_plan[byte_i][7 - bit_i];
		case (ph)
			PH_RELEASE: pn = (tcnt + 1 >= c_rd) ? !respond : 1'($urandom_range(0, 1));
			PH_RESP_LOW: pn = hold_pin(entered, 1'b0, 4);
			PH_RESP_HIGH: pn = hold_pin(entered, 1'b1, 4);
			PH_BIT_RISE: pn = hold_pin(entered, 1'b0, 3);
			PH_BIT_DELAY: begin
				if (entered)
					hold_left = bit_val ? 256 : $urandom_range(0, (c_sd == 0) ? 0 : c_sd - 1);
				pn = (hold_left != 0);
				if (hold_left != 0)
					hold_left--;
			end
			PH_BIT_FALL: pn = hold_pin(entered, 1'b1, smp ? 3 : 0);
			default: pn = 1'($urandom_range(0, 1));
		endcase
		if (noisy)
			pn = 1'($urandom_range(0, 1));
		send_tick(1'($urandom_range(0, 1)), pn, 1'b0, AT_REST);
	endtask

	task automatic measure();
		int unsigned idle_n;
		idle_n = $urandom_range(0, 3);
		repeat (idle_n)
			send_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0, AT_REST);
		plan_frame($urandom_range(0, 9) != 0);
		send_tick(1'b1, 1'($urandom_range(0, 1)), 1'b0, AT_REST);
		while (ph != PH_IDLE)
			sensor_tick();
	endtask

	task automatic run_setting(input logic [15:0] sl, input logic [15:0] rd,
			input logic [15:0] sd, input logic [15:0] to, input int unsigned runs,
			input int unsigned rate, input logic forced);
		settle();
		load_regs(sl, rd, sd, to);
		n_settings++;
		fault_rate = rate;
		force_fault = forced;
		smooth = ($urandom_range(0, 2) == 0);
		repeat (runs)
			measure();
	endtask

	initial begin
		#100_000_000;
		$display("single_wire_humidity_sensor_reader: mismatch");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED); i++)
			send_tick(DIRECTED[i].st, DIRECTED[i].pn, DIRECTED[i].typed, DIRECTED[i].want);
		settle();
		load_regs(16'd2, 16'd1, 16'd1, 16'd4);
		n_settings++;
		plan_frame(1'b1);
		noisy = 1'b0;
		while (ph != PH_IDLE)
			sensor_tick();

		run_setting(16'd0, 16'd0, 16'd0, 16'd0, 1, 30, 1'b0);
		run_setting(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)),
			16'($urandom_range(1, 3)), 16'($urandom_range(2, 16)), 1, 20, 1'b0);
		run_setting(16'd3, 16'd6, 16'd2, 16'd6, 1, 0, 1'b1);

		settle();
		repeat (8) @(posedge clk);
		if (status_due.size() != 0)
			report_mismatch("results never delivered", status_due.size(), 0);
		$display("Checked %0d status beats from %0d ticks over %0d register settings.",
			beats_seen, ticks_sent, n_settings);
		$display("Measurements: %0d latched, %0d bad checksum, %0d without answer.",
			n_latched, n_bad_sum, n_silent);
		if (mismatches == 0) begin
			$display("single_wire_humidity_sensor_reader: match");
		end else begin
			$display("single_wire_humidity_sensor_reader: mismatch");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/swhsr_pkg.sv
rtl/swhsr_core.sv
rtl/single_wire_humidity_sensor_reader.sv
sim/testbench.sv
